FILE: sv/chart_2d_table_interpolator_core_macros.svh
// Assertion macros for the chart table interpolator core.
// Used by files that assert; each use expects clk and rst_n in scope.
`ifndef CHART_2D_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define CHART_2D_TABLE_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cti_pkg.sv
// Package for the chart table interpolator: widths, codes, types and breakpoint tables.
// Self-contained; used by every module of the core.
package cti_pkg;

    localparam int XW   = 15;
    localparam int YW   = 21;
    localparam int SW   = 12;
    localparam int MW   = 33;
    localparam int PW   = SW + MW;
    localparam int UW   = 15;
    localparam int NW   = 36;
    localparam int SEGW_A = 4;
    localparam int SEGW_B = 4;
    localparam int SEGW_C = 3;

    localparam logic [15:0]   MACH_ONE = 16'd16384;
    localparam logic [XW-1:0] MACH_LO  = 15'd11469;
    localparam logic [UW-1:0] ASP_LO   = 15'd128;
    localparam logic [UW-1:0] ASP_ONE  = 15'd256;
    localparam logic [UW-1:0] ASP_TWO  = 15'd512;
    localparam logic [UW-1:0] ASP_HI   = 15'd25600;

    localparam int SLOPE_SHIFT = 23;
    localparam logic [63:0] SCALE = 64'd1 << SLOPE_SHIFT;

    localparam int LO_SHIFT  = 7;
    localparam int MID_SHIFT = 8;
    localparam int HI_SHIFT  = 9;
    localparam int HI_ODD    = (25600 - 512) >> HI_SHIFT;
    localparam int HI_RECIP_SHIFT = 29;
    localparam int HI_PW     = 23;
    localparam int HI_RW     = 24;
    localparam logic [HI_RW-1:0] HI_RECIP =
        24'(((64'd1 << HI_RECIP_SHIFT) + 64'(HI_ODD) - 64'd1) / 64'(HI_ODD));
    localparam int HI_PRODW  = HI_PW + HI_RW;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_MACH_NEG,
        STAT_ASP_NEG,
        STAT_MACH_HIGH
    } status_t;

    typedef enum logic [1:0] {
        BAND_LO,
        BAND_MID,
        BAND_HI
    } band_t;

    typedef struct packed {
        status_t       status;
        band_t         band;
        logic [UW-1:0] u;
        logic [UW-1:0] v;
    } meta_t;

    typedef struct packed {
        logic [XW-1:0]     x;
        logic [SEGW_A-1:0] seg_a;
        logic [SEGW_B-1:0] seg_b;
        logic [SEGW_C-1:0] seg_c;
    } lookup_t;

    localparam logic [63:0] KX_A [13] = '{
        11469, 11985, 13055, 13900, 14336, 14734, 15293,
        15606, 15828, 15976, 16117, 16268, 16384
    };
    localparam logic [63:0] KY_A [13] = '{
        1244567, 1191300, 1060739, 920365, 830908, 731285, 552541,
        428457, 324354, 248571, 166883, 74004, 0
    };
    localparam logic [63:0] KX_B [12] = '{
        11469, 11974, 12428, 13065, 13876, 14620,
        15297, 15728, 15972, 16129, 16215, 16384
    };
    localparam logic [63:0] KY_B [12] = '{
        528600, 520933, 511739, 488217, 438103, 370609,
        279609, 195740, 138009, 95630, 65347, 0
    };
    localparam logic [63:0] KX_C [7] = '{
        11469, 12280, 14739, 15427, 15750, 16117, 16384
    };
    localparam logic [63:0] KY_C [7] = '{
        134956, 134956, 118950, 96452, 76924, 44879, 0
    };

    // Per-segment drop over width, scaled by 2^23 and rounded up, so that a
    // multiply and shift gives the exact floor of the interpolation.
    localparam logic [MW-1:0] SLOPE_A [12] = '{
        33'(((KY_A[0] - KY_A[1]) * SCALE + KX_A[1] - KX_A[0] - 64'd1) / (KX_A[1] - KX_A[0])),
        33'(((KY_A[1] - KY_A[2]) * SCALE + KX_A[2] - KX_A[1] - 64'd1) / (KX_A[2] - KX_A[1])),
        33'(((KY_A[2] - KY_A[3]) * SCALE + KX_A[3] - KX_A[2] - 64'd1) / (KX_A[3] - KX_A[2])),
        33'(((KY_A[3] - KY_A[4]) * SCALE + KX_A[4] - KX_A[3] - 64'd1) / (KX_A[4] - KX_A[3])),
        33'(((KY_A[4] - KY_A[5]) * SCALE + KX_A[5] - KX_A[4] - 64'd1) / (KX_A[5] - KX_A[4])),
        33'(((KY_A[5] - KY_A[6]) * SCALE + KX_A[6] - KX_A[5] - 64'd1) / (KX_A[6] - KX_A[5])),
        33'(((KY_A[6] - KY_A[7]) * SCALE + KX_A[7] - KX_A[6] - 64'd1) / (KX_A[7] - KX_A[6])),
        33'(((KY_A[7] - KY_A[8]) * SCALE + KX_A[8] - KX_A[7] - 64'd1) / (KX_A[8] - KX_A[7])),
        33'(((KY_A[8] - KY_A[9]) * SCALE + KX_A[9] - KX_A[8] - 64'd1) / (KX_A[9] - KX_A[8])),
        33'(((KY_A[9] - KY_A[10]) * SCALE + KX_A[10] - KX_A[9] - 64'd1)
            / (KX_A[10] - KX_A[9])),
        33'(((KY_A[10] - KY_A[11]) * SCALE + KX_A[11] - KX_A[10] - 64'd1)
            / (KX_A[11] - KX_A[10])),
        33'(((KY_A[11] - KY_A[12]) * SCALE + KX_A[12] - KX_A[11] - 64'd1)
            / (KX_A[12] - KX_A[11]))
    };
    localparam logic [MW-1:0] SLOPE_B [11] = '{
        33'(((KY_B[0] - KY_B[1]) * SCALE + KX_B[1] - KX_B[0] - 64'd1) / (KX_B[1] - KX_B[0])),
        33'(((KY_B[1] - KY_B[2]) * SCALE + KX_B[2] - KX_B[1] - 64'd1) / (KX_B[2] - KX_B[1])),
        33'(((KY_B[2] - KY_B[3]) * SCALE + KX_B[3] - KX_B[2] - 64'd1) / (KX_B[3] - KX_B[2])),
        33'(((KY_B[3] - KY_B[4]) * SCALE + KX_B[4] - KX_B[3] - 64'd1) / (KX_B[4] - KX_B[3])),
        33'(((KY_B[4] - KY_B[5]) * SCALE + KX_B[5] - KX_B[4] - 64'd1) / (KX_B[5] - KX_B[4])),
        33'(((KY_B[5] - KY_B[6]) * SCALE + KX_B[6] - KX_B[5] - 64'd1) / (KX_B[6] - KX_B[5])),
        33'(((KY_B[6] - KY_B[7]) * SCALE + KX_B[7] - KX_B[6] - 64'd1) / (KX_B[7] - KX_B[6])),
        33'(((KY_B[7] - KY_B[8]) * SCALE + KX_B[8] - KX_B[7] - 64'd1) / (KX_B[8] - KX_B[7])),
        33'(((KY_B[8] - KY_B[9]) * SCALE + KX_B[9] - KX_B[8] - 64'd1) / (KX_B[9] - KX_B[8])),
        33'(((KY_B[9] - KY_B[10]) * SCALE + KX_B[10] - KX_B[9] - 64'd1)
            / (KX_B[10] - KX_B[9])),
        33'(((KY_B[10] - KY_B[11]) * SCALE + KX_B[11] - KX_B[10] - 64'd1)
            / (KX_B[11] - KX_B[10]))
    };
    localparam logic [MW-1:0] SLOPE_C [6] = '{
        33'(((KY_C[0] - KY_C[1]) * SCALE + KX_C[1] - KX_C[0] - 64'd1) / (KX_C[1] - KX_C[0])),
        33'(((KY_C[1] - KY_C[2]) * SCALE + KX_C[2] - KX_C[1] - 64'd1) / (KX_C[2] - KX_C[1])),
        33'(((KY_C[2] - KY_C[3]) * SCALE + KX_C[3] - KX_C[2] - 64'd1) / (KX_C[3] - KX_C[2])),
        33'(((KY_C[3] - KY_C[4]) * SCALE + KX_C[4] - KX_C[3] - 64'd1) / (KX_C[4] - KX_C[3])),
        33'(((KY_C[4] - KY_C[5]) * SCALE + KX_C[5] - KX_C[4] - 64'd1) / (KX_C[5] - KX_C[4])),
        33'(((KY_C[5] - KY_C[6]) * SCALE + KX_C[6] - KX_C[5] - 64'd1) / (KX_C[6] - KX_C[5]))
    };

endpackage

FILE: sv/chart_2d_table_interpolator_core.sv
// Top level of the chart table interpolator: stream ports, valid pipeline, stall control.
// Depends on cti_pkg, cti_front, cti_curves, cti_blend and the assertion macro header.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[15:0] mach_ratio, tdata[31:16] aspect_value
//   m_axis    out        tdata[15:0] delta_value, tuser[1:0] status
//
// Each item passes through the registers of cti_front, cti_curves and cti_blend, which include three multiplier
// stages; one item can enter every cycle while the output is not stalled.
// Reset clears the stage valid bits only.
// When a result waits at the output, every stage holds and s_axis_tready drops.
`include "chart_2d_table_interpolator_core_macros.svh"

module chart_2d_table_interpolator_core
    import cti_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // mach_ratio, aspect_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // delta_value
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int DEPTH = 6;

    logic             en;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    lookup_t          lookup;
    meta_t            meta;
    meta_t            meta_d1_reg;
    meta_t            meta_d2_reg;
    logic [YW-1:0]    y_a;
    logic [YW-1:0]    y_b;
    logic [YW-1:0]    y_c;
    logic [15:0]      delta_value;
    status_t          status;

    assign en         = !valid_reg[DEPTH-1] || m_axis_tready;
    assign valid_next = {valid_reg[DEPTH-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_d1_reg <= meta;
            meta_d2_reg <= meta_d1_reg;
        end
    end

    cti_front u_front
    (
        .clk          (clk),
        .en           (en),
        .mach_ratio   (s_axis_tdata[15:0]),
        .aspect_value (s_axis_tdata[31:16]),
        .lookup       (lookup),
        .meta         (meta)
    );

    cti_curves u_curves
    (
        .clk    (clk),
        .en     (en),
        .lookup (lookup),
        .y_a    (y_a),
        .y_b    (y_b),
        .y_c    (y_c)
    );

    cti_blend u_blend
    (
        .clk         (clk),
        .en          (en),
        .meta        (meta_d2_reg),
        .y_a         (y_a),
        .y_b         (y_b),
        .y_c         (y_c),
        .delta_value (delta_value),
        .status      (status)
    );

    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[DEPTH-1];
    assign m_axis_tdata  = delta_value;
    assign m_axis_tuser  = status;

    `CTI_ASSERT_NOW(a_err_zero, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tdata == 16'd0, "error result carries a nonzero value")
    `CTI_ASSERT_NOW(a_delta_bound, m_axis_tvalid, m_axis_tdata <= 16'd4862, "result exceeds the largest chart value")
    `CTI_ASSERT_NOW(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while the output is stalled")
    `CTI_ASSERT_NEXT(a_no_repeat, m_axis_tvalid && m_axis_tready && !valid_reg[DEPTH-2], !m_axis_tvalid, "result repeated after it was taken")

endmodule

FILE: sv/cti_front.sv
// Input stage: range checks, clamping, curve segment search and aspect band setup.
// Depends on cti_pkg.
module cti_front
    import cti_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] mach_ratio,
    input  logic [15:0] aspect_value,
    output lookup_t     lookup,
    output meta_t       meta
);

    lookup_t       lookup_reg;
    lookup_t       lookup_next;
    meta_t         meta_reg;
    meta_t         meta_next;
    logic [UW-1:0] asp;

    always_comb
    begin
        lookup_next = '0;
        meta_next   = '0;
        asp         = ASP_LO;

        if (mach_ratio[15])
        begin
            meta_next.status = STAT_MACH_NEG;
        end
        else if (aspect_value[15])
        begin
            meta_next.status = STAT_ASP_NEG;
        end
        else if (mach_ratio > MACH_ONE)
        begin
            meta_next.status = STAT_MACH_HIGH;
        end
        else
        begin
            meta_next.status = STAT_OK;
        end

        if (mach_ratio < 16'(MACH_LO))
        begin
            lookup_next.x = MACH_LO;
        end
        else
        begin
            lookup_next.x = mach_ratio[XW-1:0];
        end

        if (aspect_value < 16'(ASP_LO))
        begin
            asp = ASP_LO;
        end
        else if (aspect_value > 16'(ASP_HI))
        begin
            asp = ASP_HI;
        end
        else
        begin
            asp = aspect_value[UW-1:0];
        end

        for (int i = 1; i < 12; i++)
        begin
            if (lookup_next.x >= XW'(KX_A[i]))
            begin
                lookup_next.seg_a = SEGW_A'(i);
            end
        end
        for (int i = 1; i < 11; i++)
        begin
            if (lookup_next.x >= XW'(KX_B[i]))
            begin
                lookup_next.seg_b = SEGW_B'(i);
            end
        end
        for (int i = 1; i < 6; i++)
        begin
            if (lookup_next.x >= XW'(KX_C[i]))
            begin
                lookup_next.seg_c = SEGW_C'(i);
            end
        end

        if (asp < ASP_ONE)
        begin
            meta_next.band = BAND_LO;
            meta_next.u    = asp - ASP_LO;
            meta_next.v    = ASP_ONE - asp;
        end
        else if (asp < ASP_TWO)
        begin
            meta_next.band = BAND_MID;
            meta_next.u    = asp - ASP_ONE;
            meta_next.v    = ASP_TWO - asp;
        end
        else
        begin
            meta_next.band = BAND_HI;
            meta_next.u    = asp - ASP_TWO;
            meta_next.v    = ASP_HI - asp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lookup_reg <= lookup_next;
            meta_reg   <= meta_next;
        end
    end

    assign lookup = lookup_reg;
    assign meta   = meta_reg;

endmodule

FILE: sv/cti_curves.sv
// Two-stage evaluation of the three breakpoint curves at the clamped Mach ratio.
// Depends on cti_pkg for the knot and slope tables.
module cti_curves
    import cti_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  lookup_t       lookup,
    output logic [YW-1:0] y_a,
    output logic [YW-1:0] y_b,
    output logic [YW-1:0] y_c
);

    logic [SEGW_A-1:0] idx_a;
    logic [SEGW_B-1:0] idx_b;
    logic [SEGW_C-1:0] idx_c;
    logic [SW-1:0]     s_a;
    logic [SW-1:0]     s_b;
    logic [SW-1:0]     s_c;
    logic [PW-1:0]     prod_a_next;
    logic [PW-1:0]     prod_b_next;
    logic [PW-1:0]     prod_c_next;
    logic [YW-1:0]     y1_a_next;
    logic [YW-1:0]     y1_b_next;
    logic [YW-1:0]     y1_c_next;
    logic [PW-1:0]     prod_a_reg;
    logic [PW-1:0]     prod_b_reg;
    logic [PW-1:0]     prod_c_reg;
    logic [YW-1:0]     y1_a_reg;
    logic [YW-1:0]     y1_b_reg;
    logic [YW-1:0]     y1_c_reg;
    logic [YW-1:0]     y_a_next;
    logic [YW-1:0]     y_b_next;
    logic [YW-1:0]     y_c_next;
    logic [YW-1:0]     y_a_reg;
    logic [YW-1:0]     y_b_reg;
    logic [YW-1:0]     y_c_reg;

    // The value is the right knot plus the segment slope times the distance
    // from x to that knot; all curves fall or stay level to the right.
    always_comb
    begin
        idx_a = lookup.seg_a + SEGW_A'(1);
        idx_b = lookup.seg_b + SEGW_B'(1);
        idx_c = lookup.seg_c + SEGW_C'(1);

        s_a = SW'(XW'(KX_A[idx_a]) - lookup.x);
        s_b = SW'(XW'(KX_B[idx_b]) - lookup.x);
        s_c = SW'(XW'(KX_C[idx_c]) - lookup.x);

        prod_a_next = PW'(s_a) * PW'(SLOPE_A[lookup.seg_a]);
        prod_b_next = PW'(s_b) * PW'(SLOPE_B[lookup.seg_b]);
        prod_c_next = PW'(s_c) * PW'(SLOPE_C[lookup.seg_c]);

        y1_a_next = YW'(KY_A[idx_a]);
        y1_b_next = YW'(KY_B[idx_b]);
        y1_c_next = YW'(KY_C[idx_c]);
    end

    always_comb
    begin
        y_a_next = y1_a_reg + YW'(prod_a_reg >> SLOPE_SHIFT);
        y_b_next = y1_b_reg + YW'(prod_b_reg >> SLOPE_SHIFT);
        y_c_next = y1_c_reg + YW'(prod_c_reg >> SLOPE_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            prod_c_reg <= prod_c_next;
            y1_a_reg   <= y1_a_next;
            y1_b_reg   <= y1_b_next;
            y1_c_reg   <= y1_c_next;
            y_a_reg    <= y_a_next;
            y_b_reg    <= y_b_next;
            y_c_reg    <= y_c_next;
        end
    end

    assign y_a = y_a_reg;
    assign y_b = y_b_reg;
    assign y_c = y_c_reg;

endmodule

FILE: sv/cti_blend.sv
// Three-stage aspect blend between neighboring curves or toward zero, band scaling and output rounding.
// Depends on cti_pkg.
module cti_blend
    import cti_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  meta_t         meta,
    input  logic [YW-1:0] y_a,
    input  logic [YW-1:0] y_b,
    input  logic [YW-1:0] y_c,
    output logic [15:0]   delta_value,
    output status_t       status
);

    logic [YW-1:0]       ya_sel;
    logic [YW-1:0]       yb_sel;
    logic [NW-1:0]       n_next;
    logic [NW-1:0]       n_reg;
    band_t               band_a_reg;
    status_t             status_a_reg;
    logic [YW-1:0]       lin_next;
    logic [YW-1:0]       lin_reg;
    logic [HI_PW-1:0]    p_hi;
    logic [HI_PRODW-1:0] ph_next;
    logic [HI_PRODW-1:0] ph_reg;
    band_t               band_b_reg;
    status_t             status_b_reg;
    logic [YW-1:0]       y_fin;
    logic [15:0]         delta_next;
    logic [15:0]         delta_reg;
    status_t             status_reg;

    always_comb
    begin
        case (meta.band)
            BAND_LO:
            begin
                ya_sel = y_a;
                yb_sel = y_b;
            end
            BAND_MID:
            begin
                ya_sel = y_b;
                yb_sel = y_c;
            end
            default:
            begin
                ya_sel = y_c;
                yb_sel = '0;
            end
        endcase
        n_next = NW'(ya_sel) * NW'(meta.v) + NW'(yb_sel) * NW'(meta.u);
    end

    // The upper band width is 512 times an odd factor: shift out the power of
    // two, then divide by the odd factor through a rounded-up reciprocal.
    always_comb
    begin
        p_hi    = HI_PW'(n_reg >> HI_SHIFT);
        ph_next = HI_PRODW'(p_hi) * HI_PRODW'(HI_RECIP);
        case (band_a_reg)
            BAND_LO:  lin_next = YW'(n_reg >> LO_SHIFT);
            BAND_MID: lin_next = YW'(n_reg >> MID_SHIFT);
            default:  lin_next = '0;
        endcase
    end

    always_comb
    begin
        if (band_b_reg == BAND_HI)
        begin
            y_fin = YW'(ph_reg >> HI_RECIP_SHIFT);
        end
        else
        begin
            y_fin = lin_reg;
        end
        if (status_b_reg == STAT_OK)
        begin
            delta_next = 16'((22'(y_fin) + 22'd128) >> 8);
        end
        else
        begin
            delta_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg        <= n_next;
            band_a_reg   <= meta.band;
            status_a_reg <= meta.status;
            lin_reg      <= lin_next;
            ph_reg       <= ph_next;
            band_b_reg   <= band_a_reg;
            status_b_reg <= status_a_reg;
            delta_reg    <= delta_next;
            status_reg   <= status_b_reg;
        end
    end

    assign delta_value = delta_reg;
    assign status      = status_reg;

endmodule
